// File: rtl/core/assert_macros.svh
// assertion macros shared by the projector rtl
// no dependencies; clock clk_i and reset rst_ni are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a property on every rising clock edge outside reset
`define BCPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checks that one condition implies another in the same cycle
`define BCPP_ASSERT_IMP(lbl, pre, post, msg) \
  `BCPP_ASSERT(lbl, (pre) |-> (post), msg)

`endif

// File: rtl/core/bcpp_pkg.sv
// shared types, widths and helpers of the box corner projector
// no dependencies
`default_nettype none
package bcpp_pkg;

  localparam int CORNERS  = 8;
  localparam int CNT_W    = $clog2(CORNERS);
  localparam int POS_W    = 18;
  localparam int SUM_W    = 34;
  localparam int NUM_W    = 46;
  localparam int MAG_W    = NUM_W - 1;
  localparam int DEN_W    = 33;
  localparam int PX_W     = NUM_W;
  localparam int LO_W     = 23;
  localparam int ACC_W    = 62;
  localparam int QR_W     = ACC_W - 14;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_TAN_HFOV     = 3'd2,
    REG_TAN_VFOV     = 3'd3,
    REG_ROLL_COS     = 3'd4,
    REG_ROLL_SIN     = 3'd5,
    REG_PITCH        = 3'd6,
    REG_NONE         = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0] idx;
    logic             last;
  } corner_meta_t;

  typedef struct packed {
    corner_meta_t meta;
    logic         neg;
    logic         zero;
  } div_side_t;

  function automatic logic signed [15:0] sat16(input logic signed [QR_W:0] v);
    if (v > $signed((QR_W+1)'(32767))) begin
      sat16 = 16'sd32767;
    end else if (v < -$signed((QR_W+1)'(32768))) begin
      sat16 = -16'sd32768;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/bcpp_corner_gen.sv
// box sequencer: holds one box and issues its eight corner positions
// depends on bcpp_pkg
`default_nettype none
module bcpp_corner_gen (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  output logic                               rdy_o,
  input  wire logic signed [15:0]            x_i,
  input  wire logic [14:0]                   z_i,
  input  wire logic [14:0]                   w_i,
  input  wire logic [14:0]                   d_i,
  input  wire logic signed [15:0]            g_i,
  input  wire logic signed [15:0]            a_i,
  output logic                               vld_o,
  output bcpp_pkg::corner_meta_t             meta_o,
  output logic signed [bcpp_pkg::POS_W-1:0]  posx_o,
  output logic signed [bcpp_pkg::POS_W-1:0]  posy_o,
  output logic [15:0]                        posz_o
);
  import bcpp_pkg::*;

  logic signed [15:0] x_q, g_q, a_q;
  logic [14:0] z_q, w_q, d_q;
  logic [CNT_W-1:0] k_q;
  logic busy_q, vld_q;
  corner_meta_t meta_q;
  logic signed [POS_W-1:0] posx_q, posy_q;
  logic [15:0] posz_q;
  logic [1:0] c;
  logic is_last, take;

  assign c       = k_q[1:0];
  assign is_last = (k_q == CNT_W'(CORNERS - 1));
  assign rdy_o   = en_i && (!busy_q || is_last);
  assign take    = rdy_o && vld_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      vld_q  <= 1'b0;
    end else if (en_i) begin
      vld_q <= busy_q;
      if (take) begin
        busy_q <= 1'b1;
        k_q    <= '0;
      end else if (busy_q) begin
        k_q <= k_q + 1'b1;
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q <= x_i;
      z_q <= z_i;
      w_q <= w_i;
      d_q <= d_i;
      g_q <= g_i;
      a_q <= a_i;
    end
    if (en_i) begin
      meta_q.idx  <= k_q;
      meta_q.last <= is_last;
      posx_q <= (c == 2'd2 || c == 2'd3)
                ? $signed({{2{x_q[15]}}, x_q}) + $signed({3'b0, w_q})
                : $signed({{2{x_q[15]}}, x_q});
      posz_q <= (c == 2'd1 || c == 2'd2) ? {1'b0, z_q} + {1'b0, d_q} : {1'b0, z_q};
      posy_q <= (k_q < CNT_W'(4))
                ? $signed({{2{g_q[15]}}, g_q})
                : $signed({{2{g_q[15]}}, g_q}) - $signed({{2{a_q[15]}}, a_q});
    end
  end

  assign vld_o  = vld_q;
  assign meta_o = meta_q;
  assign posx_o = posx_q;
  assign posy_o = posy_q;
  assign posz_o = posz_q;

endmodule
`default_nettype wire

// File: rtl/core/bcpp_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on bcpp_pkg
`default_nettype none
module bcpp_div #(
  parameter int NW = bcpp_pkg::MAG_W,
  parameter int DW = bcpp_pkg::DEN_W,
  parameter int SB = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SB-1:0] sb_i,
  output logic               vld_o,
  output logic [NW-1:0]      quo_o,
  output logic [SB-1:0]      sb_o
);
  import bcpp_pkg::*;

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];
  logic [SB-1:0] sb_q  [NW];
  logic [NW-1:0] vld_q;

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] nq_in;
    logic [SB-1:0] sb_in;
    logic v_in, ge;
    logic [DW:0] t, diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign sb_in  = sb_i;
      assign v_in   = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign nq_in  = nq_q[i-1];
      assign den_in = den_q[i-1];
      assign sb_in  = sb_q[i-1];
      assign v_in   = vld_q[i-1];
    end

    assign t    = {rem_in, nq_in[NW-1]};
    assign ge   = (t >= {1'b0, den_in});
    assign diff = t - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= ge ? diff[DW-1:0] : t[DW-1:0];
        nq_q[i]  <= {nq_in[NW-2:0], ge};
        den_q[i] <= den_in;
        sb_q[i]  <= sb_in;
      end
    end
  end

  assign vld_o = vld_q[NW-1];
  assign quo_o = nq_q[NW-1];
  assign sb_o  = sb_q[NW-1];

endmodule
`default_nettype wire

// File: rtl/core/bcpp_roll.sv
// roll rotation, truncating scale, pitch shift and saturation
// depends on bcpp_pkg
`default_nettype none
module bcpp_roll (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire bcpp_pkg::corner_meta_t       meta_i,
  input  wire logic signed [bcpp_pkg::PX_W-1:0] px_i,
  input  wire logic signed [bcpp_pkg::PX_W-1:0] py_i,
  input  wire logic signed [15:0]           cos_i,
  input  wire logic signed [15:0]           sin_i,
  input  wire logic signed [12:0]           pitch_i,
  output logic                              vld_o,
  output bcpp_pkg::corner_meta_t            meta_o,
  output logic signed [15:0]                pix_x_o,
  output logic signed [15:0]                pix_y_o
);
  import bcpp_pkg::*;

  localparam int HI_W = PX_W - LO_W;
  localparam int PH_W = HI_W + 16;
  localparam int PL_W = LO_W + 17;

  logic [4:0] vld_q;
  corner_meta_t meta_q [5];

  logic signed [HI_W-1:0] hx, hy;
  logic signed [LO_W:0] lx, ly;
  logic signed [PH_W-1:0] xc_h_q, ys_h_q, xs_h_q, yc_h_q;
  logic signed [PL_W-1:0] xc_l_q, ys_l_q, xs_l_q, yc_l_q;
  logic signed [ACC_W-1:0] xc_q, ys_q, xs_q, yc_q, rx_q, ry_q;
  logic signed [QR_W-1:0] qx_q, qy_q;
  logic signed [15:0] ox_q, oy_q;

  assign hx = $signed(px_i[PX_W-1:LO_W]);
  assign hy = $signed(py_i[PX_W-1:LO_W]);
  assign lx = $signed({1'b0, px_i[LO_W-1:0]});
  assign ly = $signed({1'b0, py_i[LO_W-1:0]});

  function automatic logic signed [ACC_W-1:0] join_pp(input logic signed [PH_W-1:0] h,
                                                      input logic signed [PL_W-1:0] l);
    join_pp = (ACC_W'(h) <<< LO_W) + ACC_W'(l);
  endfunction

  function automatic logic signed [QR_W-1:0] trunc14(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] b;
    b = v + (v[ACC_W-1] ? ACC_W'(16383) : ACC_W'(0));
    trunc14 = b[ACC_W-1:14];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      meta_q[0] <= meta_i;
      for (int i = 1; i < 5; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
      xc_h_q <= hx * cos_i;
      xc_l_q <= lx * cos_i;
      ys_h_q <= hy * sin_i;
      ys_l_q <= ly * sin_i;
      xs_h_q <= hx * sin_i;
      xs_l_q <= lx * sin_i;
      yc_h_q <= hy * cos_i;
      yc_l_q <= ly * cos_i;
      xc_q <= join_pp(xc_h_q, xc_l_q);
      ys_q <= join_pp(ys_h_q, ys_l_q);
      xs_q <= join_pp(xs_h_q, xs_l_q);
      yc_q <= join_pp(yc_h_q, yc_l_q);
      rx_q <= xc_q + ys_q;
      ry_q <= yc_q - xs_q;
      qx_q <= trunc14(rx_q);
      qy_q <= trunc14(ry_q);
      ox_q <= sat16({qx_q[QR_W-1], qx_q});
      oy_q <= sat16({qy_q[QR_W-1], qy_q} + (QR_W+1)'(pitch_i));
    end
  end

  assign vld_o   = vld_q[4];
  assign meta_o  = meta_q[4];
  assign pix_x_o = ox_q;
  assign pix_y_o = oy_q;

endmodule
`default_nettype wire

// File: rtl/core/box_corner_perspective_projector_unit.sv
// top level: register port, projection arithmetic, dividers and roll stage
// depends on bcpp_pkg, bcpp_corner_gen, bcpp_div, bcpp_roll, assert_macros.svh
// Each box accepted on the slave stream yields eight corner items on the master stream, one
// per cycle while the output is not stalled, and a new box can be taken while the last corner
// of the previous box is issued. The two 45-stage pipelined dividers form the pinhole
// quotient for x and y. The whole pipeline halts together when the output is stalled, and
// registers must only be written while no box is in flight.
`default_nettype none
module box_corner_perspective_projector_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // box_x_mm, box_z_mm, box_width_mm, box_depth_mm, ground_mm, altitude_mm
  input  wire logic [95:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // corner_index, pixel_x, pixel_y
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bcpp_pkg::*;
  `include "assert_macros.svh"

  logic [11:0] img_w_q, img_h_q;
  logic [15:0] tan_h_q, tan_v_q;
  logic signed [15:0] cos_q, sin_q;
  logic signed [12:0] pitch_q;
  reg_idx_e widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 12'd640;
      img_h_q <= 12'd480;
      tan_h_q <= 16'd9459;
      tan_v_q <= 16'd6787;
      cos_q   <= 16'sd16384;
      sin_q   <= '0;
      pitch_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_IMAGE_WIDTH:  img_w_q <= pwdata[11:0];
        REG_IMAGE_HEIGHT: img_h_q <= pwdata[11:0];
        REG_TAN_HFOV:     tan_h_q <= pwdata[15:0];
        REG_TAN_VFOV:     tan_v_q <= pwdata[15:0];
        REG_ROLL_COS:     cos_q   <= pwdata[15:0];
        REG_ROLL_SIN:     sin_q   <= pwdata[15:0];
        REG_PITCH:        pitch_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_IMAGE_WIDTH:  prdata = {20'b0, img_w_q};
      REG_IMAGE_HEIGHT: prdata = {20'b0, img_h_q};
      REG_TAN_HFOV:     prdata = {16'b0, tan_h_q};
      REG_TAN_VFOV:     prdata = {16'b0, tan_v_q};
      REG_ROLL_COS:     prdata = {{16{cos_q[15]}}, cos_q};
      REG_ROLL_SIN:     prdata = {{16{sin_q[15]}}, sin_q};
      REG_PITCH:        prdata = {{19{pitch_q[12]}}, pitch_q};
      default:          prdata = '0;
    endcase
  end

  logic en;
  logic v0, v1_q, v2_q, v3_q, v4_q, v5_q;
  corner_meta_t m0, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [POS_W-1:0] posx0, posy0, posx1_q, posy1_q;
  logic [15:0] posz0;
  logic [31:0] ztx1_q, zty1_q;
  logic signed [SUM_W-1:0] sx2_q, sy2_q;
  logic [DEN_W-1:0] dx2_q, dy2_q, dx3_q, dy3_q, dx4_q, dy4_q;
  logic signed [NUM_W:0] nx_full, ny_full;
  logic signed [NUM_W-1:0] nx3_q, ny3_q, ax, ay;
  logic [MAG_W-1:0] magx4_q, magy4_q;
  div_side_t sbx4_q, sby4_q, sbx_o, sby_o;
  logic dvx, dvy;
  logic [MAG_W-1:0] qx, qy;
  logic signed [PX_W-1:0] px5_q, py5_q;
  logic rv;
  corner_meta_t rmeta;
  logic signed [15:0] pix_x, pix_y;

  assign en = !rv || m_axis_tready;

  bcpp_corner_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .rdy_o  (s_axis_tready),
    .x_i    (s_axis_tdata[15:0]),
    .z_i    (s_axis_tdata[30:16]),
    .w_i    (s_axis_tdata[45:31]),
    .d_i    (s_axis_tdata[60:46]),
    .g_i    (s_axis_tdata[76:61]),
    .a_i    (s_axis_tdata[92:77]),
    .vld_o  (v0),
    .meta_o (m0),
    .posx_o (posx0),
    .posy_o (posy0),
    .posz_o (posz0)
  );

  assign nx_full = $signed({1'b0, img_w_q}) * sx2_q;
  assign ny_full = $signed({1'b0, img_h_q}) * sy2_q;
  assign ax = nx3_q[NUM_W-1] ? -nx3_q : nx3_q;
  assign ay = ny3_q[NUM_W-1] ? -ny3_q : ny3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= dvx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q    <= m0;
      posx1_q <= posx0;
      posy1_q <= posy0;
      ztx1_q  <= posz0 * tan_h_q;
      zty1_q  <= posz0 * tan_v_q;
      m2_q    <= m1_q;
      sx2_q   <= $signed({{2{posx1_q[POS_W-1]}}, posx1_q, 14'b0}) + $signed({2'b0, ztx1_q});
      sy2_q   <= $signed({{2{posy1_q[POS_W-1]}}, posy1_q, 14'b0}) + $signed({2'b0, zty1_q});
      dx2_q   <= {ztx1_q, 1'b0};
      dy2_q   <= {zty1_q, 1'b0};
      m3_q    <= m2_q;
      nx3_q   <= nx_full[NUM_W-1:0];
      ny3_q   <= ny_full[NUM_W-1:0];
      dx3_q   <= dx2_q;
      dy3_q   <= dy2_q;
      m4_q    <= m3_q;
      magx4_q <= ax[MAG_W-1:0];
      magy4_q <= ay[MAG_W-1:0];
      dx4_q   <= dx3_q;
      dy4_q   <= dy3_q;
      sbx4_q  <= '{meta: m3_q, neg: nx3_q[NUM_W-1], zero: (dx3_q == '0)};
      sby4_q  <= '{meta: m3_q, neg: ny3_q[NUM_W-1], zero: (dy3_q == '0)};
      m5_q    <= sbx_o.meta;
      px5_q   <= sbx_o.zero ? '0
                 : (sbx_o.neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx}));
      py5_q   <= sby_o.zero ? '0
                 : (sby_o.neg ? -$signed({1'b0, qy}) : $signed({1'b0, qy}));
    end
  end

  bcpp_div #(.NW(MAG_W), .DW(DEN_W), .SB($bits(div_side_t))) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v4_q),
    .num_i  (magx4_q),
    .den_i  (dx4_q),
    .sb_i   (sbx4_q),
    .vld_o  (dvx),
    .quo_o  (qx),
    .sb_o   (sbx_o)
  );

  bcpp_div #(.NW(MAG_W), .DW(DEN_W), .SB($bits(div_side_t))) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v4_q),
    .num_i  (magy4_q),
    .den_i  (dy4_q),
    .sb_i   (sby4_q),
    .vld_o  (dvy),
    .quo_o  (qy),
    .sb_o   (sby_o)
  );

  bcpp_roll u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (v5_q),
    .meta_i  (m5_q),
    .px_i    (px5_q),
    .py_i    (py5_q),
    .cos_i   (cos_q),
    .sin_i   (sin_q),
    .pitch_i (pitch_q),
    .vld_o   (rv),
    .meta_o  (rmeta),
    .pix_x_o (pix_x),
    .pix_y_o (pix_y)
  );

  assign m_axis_tvalid = rv;
  assign m_axis_tlast  = rmeta.last;
  assign m_axis_tdata  = {5'b0, pix_y, pix_x, rmeta.idx};

  `BCPP_ASSERT_IMP(a_take_only_moving, s_axis_tready, en, "item taken while pipeline halted")
  `BCPP_ASSERT(a_div_lockstep, dvx == dvy, "divider lanes out of step")
  `BCPP_ASSERT_IMP(a_div_meta, dvx, sbx_o.meta == sby_o.meta, "divider meta out of step")
  `BCPP_ASSERT_IMP(a_last_corner, m_axis_tvalid && m_axis_tlast,
                   rmeta.idx == CNT_W'(CORNERS - 1), "last flag on wrong corner")
  `BCPP_ASSERT_IMP(a_ground_meta, v4_q && en, sbx4_q.meta == m4_q, "meta lost at divider entry")

endmodule
`default_nettype wire
